FILE: hdl/pas_pkg.sv
package pas_pkg;

  // fixed widths of the internal datapath
  localparam int unsigned DIST_W = 36;  // square root result, distance and length
  localparam int unsigned SQ_W   = 72;  // squared magnitude feeding the square root
  localparam int unsigned QUO_W  = 17;  // quotient bits of each divider

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ATTRACTOR_X   = 3'd0,
    REG_ATTRACTOR_Y   = 3'd1,
    REG_ATTRACTOR_Z   = 3'd2,
    REG_OUTER_RADIUS  = 3'd3,
    REG_MIN_DISTANCE  = 3'd4,
    REG_KILL_DISTANCE = 3'd5,
    REG_SCALED_STR    = 3'd6,
    REG_AFFECT_VEL    = 3'd7
  } reg_idx_t;

  // one particle in
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [30:0]        speed;
    logic               last_item;
  } item_t;

  // one particle out
  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [15:0] new_dir_x;
    logic signed [15:0] new_dir_y;
    logic signed [15:0] new_dir_z;
    logic [30:0]        new_speed;
    logic               killed;
    logic               affected;
    logic               last_result;
  } result_t;

  // per-particle context riding along the pipeline
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [2:0][31:0]       pos;
    logic [2:0][15:0]       dir;
    logic [30:0]            speed;
    logic [2:0][34:0]       mag;    // offset magnitudes, later velocity magnitudes
    logic [2:0]             sgn;    // matching signs
    logic                   shell;
    logic                   kill;
    logic                   fall_en;
    logic [DIST_W-1:0]      rlen;   // distance, later velocity length
    logic [2:0][31:0]       npos;
  } ctx_t;

  // signed shift right, rounded to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
                                                   input int unsigned sh);
    logic [63:0] m;
    logic [63:0] q;
    m = p[63] ? 64'(-p) : 64'(p);
    q = (m + (64'(1) << (sh - 1))) >> sh;
    return p[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

FILE: hdl/pas_sqrt.sv
module pas_sqrt #(
  parameter int XW = 72,
  parameter int RW = 36,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [XW-1:0] x,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [RW-1:0] root,
  output logic [TW-1:0] tag_out
);

  logic          vld_s  [RW];
  logic [XW-1:0] rem_s  [RW];
  logic [RW-1:0] root_s [RW];
  logic [TW-1:0] tag_s  [RW];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic          cur_v;
    logic [XW-1:0] cur_rem;
    logic [RW-1:0] cur_root;
    logic [TW-1:0] cur_tag;
    logic [XW-1:0] trial;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = x;
      assign cur_root = '0;
      assign cur_tag  = tag_in;
    end else begin : g_next
      assign cur_v    = vld_s[k-1];
      assign cur_rem  = rem_s[k-1];
      assign cur_root = root_s[k-1];
      assign cur_tag  = tag_s[k-1];
    end

    // (r + 2^b)^2 - r^2 = (2r + 2^b) * 2^b
    assign trial = (XW'(cur_root) << (B + 1)) | (XW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      tag_s[k] <= cur_tag;
      if (cur_rem >= trial) begin
        rem_s[k]  <= cur_rem - trial;
        root_s[k] <= cur_root | (RW'(1) << B);
      end else begin
        rem_s[k]  <= cur_rem;
        root_s[k] <= cur_root;
      end
    end
  end

  assign out_valid = vld_s[RW-1];
  assign root      = root_s[RW-1];
  assign tag_out   = tag_s[RW-1];

endmodule

FILE: hdl/pas_div.sv
module pas_div #(
  parameter int NW = 48,
  parameter int DW = 36,
  parameter int QW = 17,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  localparam int MW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld_s [QW];
  logic [MW-1:0] rem_s [QW];
  logic [DW-1:0] den_s [QW];
  logic [QW-1:0] quo_s [QW];
  logic [TW-1:0] tag_s [QW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic          cur_v;
    logic [MW-1:0] cur_rem;
    logic [DW-1:0] cur_den;
    logic [QW-1:0] cur_quo;
    logic [TW-1:0] cur_tag;
    logic [MW-1:0] trial;

    if (k == 0) begin : g_first
      assign cur_v   = in_valid;
      assign cur_rem = MW'(num);
      assign cur_den = den;
      assign cur_quo = '0;
      assign cur_tag = tag_in;
    end else begin : g_next
      assign cur_v   = vld_s[k-1];
      assign cur_rem = rem_s[k-1];
      assign cur_den = den_s[k-1];
      assign cur_quo = quo_s[k-1];
      assign cur_tag = tag_s[k-1];
    end

    assign trial = MW'(cur_den) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      den_s[k] <= cur_den;
      tag_s[k] <= cur_tag;
      if (cur_rem >= trial) begin
        rem_s[k] <= cur_rem - trial;
        quo_s[k] <= cur_quo | (QW'(1) << B);
      end else begin
        rem_s[k] <= cur_rem;
        quo_s[k] <= cur_quo;
      end
    end
  end

  assign out_valid = vld_s[QW-1];
  assign quo       = quo_s[QW-1];
  assign tag_out   = tag_s[QW-1];

endmodule

FILE: hdl/particle_attractor_step.sv
// Point attractor applied to a stream of particles. One particle word is taken on every
// clock at which start is high (busy is always low) and its result word appears on result
// for one cycle with done high, in order; the receiver cannot stall. The latency is set
// by two 36-stage square root pipelines (particle distance and new velocity length) and
// two 17-stage divider pipelines (unit direction and falloff, then the renormalized
// direction), plus the multiply and rounding stages between them.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and must
// only change while no particle is in flight.
module particle_attractor_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pas_pkg::item_t      item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                done,
  output pas_pkg::result_t    result
);

  localparam int DW      = pas_pkg::DIST_W;
  localparam int QW      = pas_pkg::QUO_W;
  localparam int CTX_W   = $bits(pas_pkg::ctx_t);
  localparam int LATENCY = 3 + DW + 1 + QW + 10 + DW + 1 + QW + 1;

  // configuration registers
  logic signed [31:0] attractor_x, attractor_y, attractor_z, scaled_strength;
  logic [30:0]        outer_radius, min_distance, kill_distance;
  logic               affect_velocity;
  logic [61:0]        rsq, msq;

  always_ff @(posedge clk) begin
    if (rst) begin
      attractor_x     <= '0;
      attractor_y     <= '0;
      attractor_z     <= '0;
      outer_radius    <= '0;
      min_distance    <= '0;
      kill_distance   <= '0;
      scaled_strength <= '0;
      affect_velocity <= 1'b1;
    end else if (cfg_we) begin
      case (pas_pkg::reg_idx_t'(cfg_index))
        pas_pkg::REG_ATTRACTOR_X:   attractor_x     <= cfg_data;
        pas_pkg::REG_ATTRACTOR_Y:   attractor_y     <= cfg_data;
        pas_pkg::REG_ATTRACTOR_Z:   attractor_z     <= cfg_data;
        pas_pkg::REG_OUTER_RADIUS:  outer_radius    <= cfg_data[30:0];
        pas_pkg::REG_MIN_DISTANCE:  min_distance    <= cfg_data[30:0];
        pas_pkg::REG_KILL_DISTANCE: kill_distance   <= cfg_data[30:0];
        pas_pkg::REG_SCALED_STR:    scaled_strength <= cfg_data;
        pas_pkg::REG_AFFECT_VEL:    affect_velocity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // squared shell radii, registered from the radius registers
  always_ff @(posedge clk) begin
    rsq <= 62'(outer_radius) * 62'(outer_radius);
    msq <= 62'(min_distance) * 62'(min_distance);
  end

  assign busy = 1'b0;

  // stage 1: offset to the attractor and its magnitude
  pas_pkg::ctx_t      c1_next, c1;
  logic signed [31:0] pin [3];
  logic signed [31:0] att [3];
  logic signed [32:0] to_c [3];

  always_comb begin
    pin[0] = item.pos_x;
    pin[1] = item.pos_y;
    pin[2] = item.pos_z;
    att[0] = attractor_x;
    att[1] = attractor_y;
    att[2] = attractor_z;
    c1_next       = '0;
    c1_next.valid = start && !busy;
    c1_next.last  = item.last_item;
    c1_next.dir[0] = item.dir_x;
    c1_next.dir[1] = item.dir_y;
    c1_next.dir[2] = item.dir_z;
    c1_next.speed = item.speed;
    for (int i = 0; i < 3; i++) begin
      to_c[i] = 33'(att[i]) - 33'(pin[i]);
      c1_next.pos[i] = pin[i];
      c1_next.sgn[i] = to_c[i][32];
      c1_next.mag[i] = to_c[i][32] ? 35'(33'(-to_c[i])) : 35'(33'(to_c[i]));
    end
  end

  always_ff @(posedge clk) begin
    c1 <= c1_next;
    if (rst) c1.valid <= 1'b0;
  end

  // stage 2: squares
  pas_pkg::ctx_t c2;
  logic [65:0]   sq [3];

  always_ff @(posedge clk) begin
    c2 <= c1;
    if (rst) c2.valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      sq[i] <= 66'(c1.mag[i][32:0]) * 66'(c1.mag[i][32:0]);
    end
  end

  // stage 3: squared distance
  pas_pkg::ctx_t c3, c3t;
  logic [67:0]   dsq;

  always_ff @(posedge clk) begin
    c3 <= c2;
    if (rst) c3.valid <= 1'b0;
    dsq <= 68'(sq[0]) + 68'(sq[1]) + 68'(sq[2]);
  end

  // shell test on exact squares
  always_comb begin
    c3t       = c3;
    c3t.shell = (dsq < 68'(rsq)) && (dsq > 68'(msq));
  end

  // distance
  logic              q1_valid;
  logic [DW-1:0]     dist_root;
  logic [CTX_W-1:0]  q1_bits;
  pas_pkg::ctx_t     q1;

  pas_sqrt #(.XW(pas_pkg::SQ_W), .RW(DW), .TW(CTX_W)) u_sqrt_dist (
    .clk(clk), .rst(rst), .in_valid(c3.valid), .x(pas_pkg::SQ_W'(dsq)),
    .tag_in(c3t), .out_valid(q1_valid), .root(dist_root), .tag_out(q1_bits)
  );
  assign q1 = pas_pkg::ctx_t'(q1_bits);

  // stage 4: kill test, divider operands
  pas_pkg::ctx_t c4;
  logic [47:0]   num_t [3];
  logic [46:0]   fall_num;
  logic [30:0]   fall_den;

  always_ff @(posedge clk) begin
    c4         <= q1;
    c4.valid   <= q1_valid && !rst;
    c4.rlen    <= dist_root;
    c4.kill    <= dist_root < DW'(kill_distance);
    c4.fall_en <= outer_radius > min_distance;
    for (int i = 0; i < 3; i++) begin
      num_t[i] <= 48'({q1.mag[i][32:0], 14'd0}) + 48'(dist_root[DW-1:1]);
    end
    fall_num <= {31'(outer_radius - dist_root[30:0]), 16'd0};
    fall_den <= 31'(outer_radius - min_distance);
  end

  // unit direction toward the attractor and falloff
  logic [QW-1:0]    tq [3];
  logic [QW-1:0]    fq;
  logic             d1_valid;
  logic [CTX_W-1:0] d1_bits;
  pas_pkg::ctx_t    d1;

  for (genvar i = 0; i < 3; i++) begin : g_div_dir
    pas_div #(.NW(48), .DW(DW), .QW(QW), .TW(1)) u_div (
      .clk(clk), .rst(rst), .in_valid(c4.valid), .num(num_t[i]), .den(c4.rlen),
      .tag_in(1'b0), .out_valid(), .quo(tq[i]), .tag_out()
    );
  end

  pas_div #(.NW(47), .DW(31), .QW(QW), .TW(CTX_W)) u_div_fall (
    .clk(clk), .rst(rst), .in_valid(c4.valid), .num(fall_num), .den(fall_den),
    .tag_in(c4), .out_valid(d1_valid), .quo(fq), .tag_out(d1_bits)
  );
  assign d1 = pas_pkg::ctx_t'(d1_bits);

  // stage 5: signed direction, gated falloff
  pas_pkg::ctx_t      c5;
  logic signed [15:0] tdir5 [3];
  logic [QW-1:0]      fall5;

  always_ff @(posedge clk) begin
    c5       <= d1;
    c5.valid <= d1_valid && !rst;
    fall5    <= d1.fall_en ? fq : '0;
    for (int i = 0; i < 3; i++) begin
      tdir5[i] <= d1.sgn[i] ? -$signed(16'(tq[i])) : $signed(16'(tq[i]));
    end
  end

  // stage 6: push and velocity products
  pas_pkg::ctx_t      c6;
  logic signed [49:0] prod_a;
  logic signed [47:0] prod_v [3];
  logic signed [15:0] tdir6 [3];

  always_ff @(posedge clk) begin
    c6 <= c5;
    if (rst) c6.valid <= 1'b0;
    prod_a <= scaled_strength * $signed({1'b0, fall5});
    for (int i = 0; i < 3; i++) begin
      prod_v[i] <= $signed(c5.dir[i]) * $signed({1'b0, c5.speed});
      tdir6[i]  <= tdir5[i];
    end
  end

  // stage 7: rounding, largest allowed move
  pas_pkg::ctx_t      c7;
  logic signed [33:0] amount7;
  logic signed [33:0] vterm7 [3];
  logic signed [36:0] maxmove7;
  logic signed [15:0] tdir7 [3];

  always_ff @(posedge clk) begin
    c7 <= c6;
    if (rst) c7.valid <= 1'b0;
    amount7  <= 34'(pas_pkg::rnd_shift(64'(prod_a), 16));
    maxmove7 <= $signed({1'b0, c6.rlen}) - $signed({6'd0, min_distance});
    for (int i = 0; i < 3; i++) begin
      vterm7[i] <= 34'(pas_pkg::rnd_shift(64'(prod_v[i]), 14));
      tdir7[i]  <= tdir6[i];
    end
  end

  // stage 8: clamp the move at the inner shell
  pas_pkg::ctx_t      c8;
  logic signed [33:0] amount8;
  logic signed [36:0] mv8;
  logic signed [33:0] vterm8 [3];
  logic signed [15:0] tdir8 [3];

  always_ff @(posedge clk) begin
    c8 <= c7;
    if (rst) c8.valid <= 1'b0;
    amount8 <= amount7;
    mv8     <= (37'(amount7) < maxmove7) ? 37'(amount7) : maxmove7;
    for (int i = 0; i < 3; i++) begin
      vterm8[i] <= vterm7[i];
      tdir8[i]  <= tdir7[i];
    end
  end

  // stage 9: per-axis push products
  pas_pkg::ctx_t      c9;
  logic signed [49:0] pa9 [3];
  logic signed [52:0] pm9 [3];
  logic signed [33:0] vterm9 [3];

  always_ff @(posedge clk) begin
    c9 <= c8;
    if (rst) c9.valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      pa9[i]    <= tdir8[i] * amount8;
      pm9[i]    <= tdir8[i] * mv8;
      vterm9[i] <= vterm8[i];
    end
  end

  // stage 10: rounding of the pushes
  pas_pkg::ctx_t      c10;
  logic signed [35:0] pterm10 [3];
  logic signed [38:0] mterm10 [3];
  logic signed [33:0] vterm10 [3];

  always_ff @(posedge clk) begin
    c10 <= c9;
    if (rst) c10.valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      pterm10[i] <= 36'(pas_pkg::rnd_shift(64'(pa9[i]), 14));
      mterm10[i] <= 39'(pas_pkg::rnd_shift(64'(pm9[i]), 14));
      vterm10[i] <= vterm9[i];
    end
  end

  // stage 11: new velocity, moved and saturated position
  pas_pkg::ctx_t      c11_next, c11;
  logic signed [35:0] nv11 [3];
  logic signed [39:0] psum [3];

  always_comb begin
    c11_next = c10;
    for (int i = 0; i < 3; i++) begin
      psum[i] = 40'($signed(c10.pos[i])) + 40'(mterm10[i]);
      if (psum[i] > 40'sh007FFFFFFF) begin
        c11_next.npos[i] = 32'h7FFF_FFFF;
      end else if (psum[i] < -40'sh0080000000) begin
        c11_next.npos[i] = 32'h8000_0000;
      end else begin
        c11_next.npos[i] = psum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    c11 <= c11_next;
    if (rst) c11.valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      nv11[i] <= 36'(vterm10[i]) + pterm10[i];
    end
  end

  // stage 12: velocity magnitudes and signs
  pas_pkg::ctx_t c12;

  always_ff @(posedge clk) begin
    c12 <= c11;
    if (rst) c12.valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      c12.sgn[i] <= nv11[i][35];
      c12.mag[i] <= nv11[i][35] ? 35'(-nv11[i]) : 35'(nv11[i]);
    end
  end

  // stage 13: squares of the velocity
  pas_pkg::ctx_t c13;
  logic [69:0]   sq2 [3];

  always_ff @(posedge clk) begin
    c13 <= c12;
    if (rst) c13.valid <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= 70'(c12.mag[i]) * 70'(c12.mag[i]);
    end
  end

  // stage 14: squared length
  pas_pkg::ctx_t             c14;
  logic [pas_pkg::SQ_W-1:0]  sum2;

  always_ff @(posedge clk) begin
    c14 <= c13;
    if (rst) c14.valid <= 1'b0;
    sum2 <= pas_pkg::SQ_W'(sq2[0]) + pas_pkg::SQ_W'(sq2[1]) + pas_pkg::SQ_W'(sq2[2]);
  end

  // velocity length
  logic              q2_valid;
  logic [DW-1:0]     len;
  logic [CTX_W-1:0]  q2_bits;
  pas_pkg::ctx_t     q2;

  pas_sqrt #(.XW(pas_pkg::SQ_W), .RW(DW), .TW(CTX_W)) u_sqrt_len (
    .clk(clk), .rst(rst), .in_valid(c14.valid), .x(sum2),
    .tag_in(c14), .out_valid(q2_valid), .root(len), .tag_out(q2_bits)
  );
  assign q2 = pas_pkg::ctx_t'(q2_bits);

  // stage 15: renormalize operands
  pas_pkg::ctx_t c15;
  logic [49:0]   num_n [3];

  always_ff @(posedge clk) begin
    c15       <= q2;
    c15.valid <= q2_valid && !rst;
    c15.rlen  <= len;
    for (int i = 0; i < 3; i++) begin
      num_n[i] <= 50'({q2.mag[i], 14'd0}) + 50'(len[DW-1:1]);
    end
  end

  // new unit direction
  logic [QW-1:0]    nq [3];
  logic             d2_valid;
  logic [CTX_W-1:0] d2_bits;
  pas_pkg::ctx_t    d2;

  pas_div #(.NW(50), .DW(DW), .QW(QW), .TW(CTX_W)) u_div_nx (
    .clk(clk), .rst(rst), .in_valid(c15.valid), .num(num_n[0]), .den(c15.rlen),
    .tag_in(c15), .out_valid(d2_valid), .quo(nq[0]), .tag_out(d2_bits)
  );

  for (genvar i = 1; i < 3; i++) begin : g_div_norm
    pas_div #(.NW(50), .DW(DW), .QW(QW), .TW(1)) u_div (
      .clk(clk), .rst(rst), .in_valid(c15.valid), .num(num_n[i]), .den(c15.rlen),
      .tag_in(1'b0), .out_valid(), .quo(nq[i]), .tag_out()
    );
  end
  assign d2 = pas_pkg::ctx_t'(d2_bits);

  // output word selection
  pas_pkg::result_t   res_next;
  logic               aff;
  logic signed [15:0] ndir [3];

  always_comb begin
    aff = !d2.kill && d2.shell;
    for (int i = 0; i < 3; i++) begin
      if (d2.rlen == '0) begin
        ndir[i] = '0;
      end else begin
        ndir[i] = d2.sgn[i] ? -$signed(16'(nq[i])) : $signed(16'(nq[i]));
      end
    end
    res_next.new_pos_x   = d2.pos[0];
    res_next.new_pos_y   = d2.pos[1];
    res_next.new_pos_z   = d2.pos[2];
    res_next.new_dir_x   = d2.dir[0];
    res_next.new_dir_y   = d2.dir[1];
    res_next.new_dir_z   = d2.dir[2];
    res_next.new_speed   = d2.speed;
    res_next.killed      = d2.kill;
    res_next.affected    = aff;
    res_next.last_result = d2.last;
    if (aff && affect_velocity) begin
      res_next.new_dir_x = ndir[0];
      res_next.new_dir_y = ndir[1];
      res_next.new_dir_z = ndir[2];
      res_next.new_speed = (d2.rlen > DW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : d2.rlen[30:0];
    end else if (aff) begin
      res_next.new_pos_x = d2.npos[0];
      res_next.new_pos_y = d2.npos[1];
      res_next.new_pos_z = d2.npos[2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_valid;
    end
  end

  // every result word comes from a particle taken a fixed latency earlier
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result word without a matching particle");

  // the pass marker travels with its particle
  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> result.last_result == $past(item.last_item, LATENCY))
    else $error("last marker out of step");

  // a killed particle is never also attracted
  a_kill_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.killed && result.affected))
    else $error("killed and affected both set");

  // a particle taken in is always delivered
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("particle lost in the pipeline");

endmodule
